/* design/pclip_pkg.sv */
`timescale 1ns / 1ps
// Shared codes and reset constants for the pen line clipper.
package pclip_pkg;

  typedef enum logic [1:0] {
    REQ_MOVE_ABS = 2'd0,
    REQ_MOVE_REL = 2'd1,
    REQ_DRAW_ABS = 2'd2,
    REQ_DRAW_REL = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_MOVE      = 2'd0,
    ST_UNCLIPPED = 2'd1,
    ST_CLIPPED   = 2'd2,
    ST_REJECT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_LEFT   = 2'd0,
    CFG_RIGHT  = 2'd1,
    CFG_TOP    = 2'd2,
    CFG_BOTTOM = 2'd3
  } cfg_index_t;

  localparam int CLIP_LEFT_RST   = 0;
  localparam int CLIP_RIGHT_RST  = 1023;
  localparam int CLIP_TOP_RST    = 0;
  localparam int CLIP_BOTTOM_RST = 767;

endpackage

/* design/pclip_if.sv */
`timescale 1ns / 1ps
// Request and result channel interfaces.
interface pclip_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  modport source (output valid, req_type, coord_x, coord_y, input ready);
  modport sink (input valid, req_type, coord_x, coord_y, output ready);
endinterface

interface pclip_out_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  modport source (output valid, status, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, status, start_x, start_y, end_x, end_y, output ready);
endinterface

/* design/pclip_front.sv */
`timescale 1ns / 1ps
// Front end: takes requests, keeps the pen and queues segments.
module pclip_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  pclip_in_if.sink                in_ch,
  output logic                    push_valid,
  input  logic                    push_ready,
  output logic [4*COORD_BITS:0]   push_data
);

  localparam int W = COORD_BITS;

  logic signed [W-1:0] pen_x_r, pen_x_nxt;
  logic signed [W-1:0] pen_y_r, pen_y_nxt;
  logic                rel;
  logic                draw;
  logic signed [W:0]   sum_x, sum_y;

  always_comb begin
    rel  = (in_ch.req_type == pclip_pkg::REQ_MOVE_REL) ||
           (in_ch.req_type == pclip_pkg::REQ_DRAW_REL);
    draw = (in_ch.req_type == pclip_pkg::REQ_DRAW_ABS) ||
           (in_ch.req_type == pclip_pkg::REQ_DRAW_REL);
    sum_x = {pen_x_r[W-1], pen_x_r} + {in_ch.coord_x[W-1], in_ch.coord_x};
    sum_y = {pen_y_r[W-1], pen_y_r} + {in_ch.coord_y[W-1], in_ch.coord_y};
    pen_x_nxt = in_ch.coord_x;
    pen_y_nxt = in_ch.coord_y;
    if (rel) begin
      // saturate on overflow of the relative sum
      if (sum_x[W] != sum_x[W-1]) begin
        pen_x_nxt = sum_x[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        pen_x_nxt = sum_x[W-1:0];
      end
      if (sum_y[W] != sum_y[W-1]) begin
        pen_y_nxt = sum_y[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        pen_y_nxt = sum_y[W-1:0];
      end
    end
  end

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign push_data   = {draw, pen_x_r, pen_y_r, pen_x_nxt, pen_y_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else if (in_ch.valid && push_ready) begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

endmodule

/* design/pclip_fifo.sv */
`timescale 1ns / 1ps
// Two-entry queue between front and back.
module pclip_fifo #(
  parameter int WIDTH = 65
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

/* design/pclip_along.sv */
`timescale 1ns / 1ps
// Line equation unit: w = w0 + rounded (dw*(v-v0))/dv, one quotient bit per cycle.
module pclip_along #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COORD_BITS-1:0] v,
  input  logic signed [COORD_BITS-1:0] v0,
  input  logic signed [COORD_BITS-1:0] w0,
  input  logic signed [COORD_BITS:0]   dv,
  input  logic signed [COORD_BITS:0]   dw,
  output logic                      done,
  output logic signed [COORD_BITS+2:0] w
);

  localparam int W    = COORD_BITS;
  localparam int PW   = 2 * W + 2;
  localparam int CNTW = $clog2(W + 2);

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_PREP, A_DIV, A_FIN} astate_t;

  astate_t             state_r;
  logic [W:0]          ad_r, aw_r, av_r;
  logic                neg_r, zero_r;
  logic signed [W-1:0] w0_r;
  logic [PW-1:0]       prod_r;
  logic [W:0]          rem_r;
  logic [W+1:0]        lo_r;
  logic [W+1:0]        q_r;
  logic [CNTW-1:0]     cnt_r;
  logic                done_r;
  logic signed [W+2:0] w_r;

  logic signed [W:0]   d;
  logic [PW-1:0]       num;
  logic [W+1:0]        rem2;
  logic                ge;
  logic signed [W+2:0] w0e, qe;

  always_comb begin
    d    = {v[W-1], v} - {v0[W-1], v0};
    num  = prod_r + PW'(av_r >> 1);
    rem2 = {rem_r, lo_r[W+1]};
    ge   = (rem2 >= {1'b0, av_r});
    w0e  = {{3{w0_r[W-1]}}, w0_r};
    qe   = {1'b0, q_r};
  end

  assign done = done_r;
  assign w    = w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        A_IDLE: begin
          if (start) begin
            ad_r    <= d[W] ? (W+1)'(-d) : d;
            aw_r    <= dw[W] ? (W+1)'(-dw) : dw;
            av_r    <= dv[W] ? (W+1)'(-dv) : dv;
            neg_r   <= d[W] ^ dw[W] ^ dv[W];
            zero_r  <= (dv == '0);
            w0_r    <= w0;
            state_r <= A_MUL;
          end
        end
        A_MUL: begin
          prod_r  <= PW'(aw_r) * PW'(ad_r);
          state_r <= A_PREP;
        end
        A_PREP: begin
          q_r <= '0;
          if (zero_r) begin
            state_r <= A_FIN;
          end else if (num[PW-1:W+1] >= av_r) begin
            // far outside any window; a saturated quotient keeps the direction
            q_r     <= {1'b1, {(W+1){1'b0}}};
            state_r <= A_FIN;
          end else begin
            rem_r   <= {1'b0, num[PW-1:W+2]};
            lo_r    <= num[W+1:0];
            cnt_r   <= CNTW'(W + 1);
            state_r <= A_DIV;
          end
        end
        A_DIV: begin
          rem_r <= ge ? (W+1)'(rem2 - {1'b0, av_r}) : rem2[W:0];
          lo_r  <= {lo_r[W:0], 1'b0};
          q_r   <= {q_r[W:0], ge};
          if (cnt_r == '0) begin
            state_r <= A_FIN;
          end else begin
            cnt_r <= cnt_r - CNTW'(1);
          end
        end
        A_FIN: begin
          w_r     <= neg_r ? (w0e - qe) : (w0e + qe);
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

endmodule

/* design/pclip_back.sv */
`timescale 1ns / 1ps
// Back end: clip window registers, endpoint clipping sequencer and result register.
module pclip_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  logic [4*COORD_BITS:0] pop_data,
  pclip_out_if.source           out_ch
);

  localparam int W  = COORD_BITS;
  localparam int XW = W + 3;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIV, S_CX, S_WY1, S_WX2, S_CY, S_WX3, S_WY4, S_FIN, S_OUT
  } state_t;

  state_t               state_r;
  logic signed [W-1:0]  left_r, right_r, top_r, bottom_r;
  logic signed [W-1:0]  x0_r, y0_r, x2_r, y2_r;
  logic signed [W:0]    dx_r, dy_r;
  logic signed [XW-1:0] px_r, py_r;
  logic                 ep_r, moved_r;
  logic signed [W-1:0]  sx_r, sy_r;
  logic [1:0]           res_status_r;
  logic signed [W-1:0]  res_sx_r, res_sy_r, res_ex_r, res_ey_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic signed [W-1:0]  out_sx_r, out_sy_r, out_ex_r, out_ey_r;
  logic                 al_start_r, al_xaxis_r;
  logic signed [W-1:0]  al_v_r;

  logic                 al_done;
  logic signed [XW-1:0] al_w;
  logic signed [XW-1:0] lft_e, rgt_e, top_e, bot_e;
  logic                 x_lo, x_hi, y_lo, y_hi;
  logic                 wx_lo, wx_hi, wy_lo, wy_hi;
  logic signed [W-1:0]  q_x1, q_y1, q_x2, q_y2;
  logic                 q_draw;

  assign {q_draw, q_x1, q_y1, q_x2, q_y2} = pop_data;

  always_comb begin
    lft_e = {{3{left_r[W-1]}}, left_r};
    rgt_e = {{3{right_r[W-1]}}, right_r};
    top_e = {{3{top_r[W-1]}}, top_r};
    bot_e = {{3{bottom_r[W-1]}}, bottom_r};
    x_lo  = px_r < lft_e;
    x_hi  = px_r > rgt_e;
    y_lo  = py_r < top_e;
    y_hi  = py_r > bot_e;
    wx_lo = al_w < lft_e;
    wx_hi = al_w > rgt_e;
    wy_lo = al_w < top_e;
    wy_hi = al_w > bot_e;
  end

  pclip_along #(.COORD_BITS(W)) u_along (
    .clk   (clk),
    .rst_n (rst_n),
    .start (al_start_r),
    .v     (al_v_r),
    .v0    (al_xaxis_r ? x0_r : y0_r),
    .w0    (al_xaxis_r ? y0_r : x0_r),
    .dv    (al_xaxis_r ? dx_r : dy_r),
    .dw    (al_xaxis_r ? dy_r : dx_r),
    .done  (al_done),
    .w     (al_w)
  );

  assign pop_ready      = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.start_x = out_sx_r;
  assign out_ch.start_y = out_sy_r;
  assign out_ch.end_x   = out_ex_r;
  assign out_ch.end_y   = out_ey_r;

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= W'(pclip_pkg::CLIP_LEFT_RST);
      right_r  <= W'(pclip_pkg::CLIP_RIGHT_RST);
      top_r    <= W'(pclip_pkg::CLIP_TOP_RST);
      bottom_r <= W'(pclip_pkg::CLIP_BOTTOM_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pclip_pkg::CFG_LEFT:   left_r   <= cfg_wdata;
        pclip_pkg::CFG_RIGHT:  right_r  <= cfg_wdata;
        pclip_pkg::CFG_TOP:    top_r    <= cfg_wdata;
        pclip_pkg::CFG_BOTTOM: bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      al_start_r  <= 1'b0;
    end else begin
      al_start_r <= 1'b0;
      // S_OUT reloads the result register itself
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            x0_r <= q_x1;
            y0_r <= q_y1;
            x2_r <= q_x2;
            y2_r <= q_y2;
            dx_r <= {q_x2[W-1], q_x2} - {q_x1[W-1], q_x1};
            dy_r <= {q_y2[W-1], q_y2} - {q_y1[W-1], q_y1};
            res_status_r <= pclip_pkg::ST_MOVE;
            res_sx_r <= '0;
            res_sy_r <= '0;
            res_ex_r <= '0;
            res_ey_r <= '0;
            state_r  <= q_draw ? S_TRIV : S_OUT;
          end
        end
        S_TRIV: begin
          // both endpoints beyond the same edge
          if ((x0_r < left_r && x2_r < left_r) || (x0_r > right_r && x2_r > right_r) ||
              (y0_r < top_r && y2_r < top_r) || (y0_r > bottom_r && y2_r > bottom_r)) begin
            res_status_r <= pclip_pkg::ST_REJECT;
            state_r      <= S_OUT;
          end else begin
            px_r    <= {{3{x0_r[W-1]}}, x0_r};
            py_r    <= {{3{y0_r[W-1]}}, y0_r};
            ep_r    <= 1'b0;
            moved_r <= 1'b0;
            state_r <= S_CX;
          end
        end
        S_CX: begin
          if (x_lo || x_hi) begin
            if (dx_r == '0) begin
              res_status_r <= pclip_pkg::ST_REJECT;
              state_r      <= S_OUT;
            end else begin
              px_r       <= x_lo ? lft_e : rgt_e;
              al_v_r     <= x_lo ? left_r : right_r;
              al_xaxis_r <= 1'b1;
              al_start_r <= 1'b1;
              moved_r    <= 1'b1;
              state_r    <= S_WY1;
            end
          end else begin
            state_r <= S_CY;
          end
        end
        S_WY1: begin
          if (al_done) begin
            py_r <= al_w;
            if (wy_lo || wy_hi) begin
              if (dy_r == '0) begin
                res_status_r <= pclip_pkg::ST_REJECT;
                state_r      <= S_OUT;
              end else begin
                py_r       <= wy_lo ? top_e : bot_e;
                al_v_r     <= wy_lo ? top_r : bottom_r;
                al_xaxis_r <= 1'b0;
                al_start_r <= 1'b1;
                state_r    <= S_WX2;
              end
            end else begin
              state_r <= S_CY;
            end
          end
        end
        S_WX2: begin
          if (al_done) begin
            px_r <= al_w;
            if (wx_lo || wx_hi) begin
              res_status_r <= pclip_pkg::ST_REJECT;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_CY;
            end
          end
        end
        S_CY: begin
          if (y_lo || y_hi) begin
            if (dy_r == '0) begin
              res_status_r <= pclip_pkg::ST_REJECT;
              state_r      <= S_OUT;
            end else begin
              py_r       <= y_lo ? top_e : bot_e;
              al_v_r     <= y_lo ? top_r : bottom_r;
              al_xaxis_r <= 1'b0;
              al_start_r <= 1'b1;
              moved_r    <= 1'b1;
              state_r    <= S_WX3;
            end
          end else begin
            state_r <= S_FIN;
          end
        end
        S_WX3: begin
          if (al_done) begin
            px_r <= al_w;
            if (wx_lo || wx_hi) begin
              if (dx_r == '0) begin
                res_status_r <= pclip_pkg::ST_REJECT;
                state_r      <= S_OUT;
              end else begin
                px_r       <= wx_lo ? lft_e : rgt_e;
                al_v_r     <= wx_lo ? left_r : right_r;
                al_xaxis_r <= 1'b1;
                al_start_r <= 1'b1;
                state_r    <= S_WY4;
              end
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_WY4: begin
          if (al_done) begin
            py_r <= al_w;
            if (wy_lo || wy_hi) begin
              res_status_r <= pclip_pkg::ST_REJECT;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!ep_r) begin
            sx_r    <= px_r[W-1:0];
            sy_r    <= py_r[W-1:0];
            px_r    <= {{3{x2_r[W-1]}}, x2_r};
            py_r    <= {{3{y2_r[W-1]}}, y2_r};
            ep_r    <= 1'b1;
            state_r <= S_CX;
          end else begin
            res_status_r <= moved_r ? pclip_pkg::ST_CLIPPED : pclip_pkg::ST_UNCLIPPED;
            res_sx_r     <= sx_r;
            res_sy_r     <= sy_r;
            res_ex_r     <= px_r[W-1:0];
            res_ey_r     <= py_r[W-1:0];
            state_r      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_sx_r     <= res_sx_r;
            out_sy_r     <= res_sy_r;
            out_ex_r     <= res_ex_r;
            out_ey_r     <= res_ey_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/pen_line_clipper_top.sv */
`timescale 1ns / 1ps
// Top level of the pen line clipper.
// Move: the back end passes from S_IDLE to S_OUT and registers the result.
// Draw: trivial rejection comes first; otherwise each line equation solve runs
// in the shared divide unit, at most four per draw.
// A two-entry queue lets requests enter while the clipper works.
// Synchronous active-low reset clears pen to 0 and the window to 0,1023,0,767.
module pen_line_clipper_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pclip_in_if.sink              in_ch,
  pclip_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_wdata
);

  localparam int QW = 4 * COORD_BITS + 1;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0] push_data, pop_data;

  pclip_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pclip_fifo #(.WIDTH(QW)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pclip_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

/* design/pclip_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the pen line clipper, bound to the top level.
module pclip_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_status,
  input logic [COORD_BITS-1:0] out_start_x,
  input logic [COORD_BITS-1:0] out_start_y,
  input logic [COORD_BITS-1:0] out_end_x,
  input logic [COORD_BITS-1:0] out_end_y
);

  logic [2:0] pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
    end else begin
      pending_r <= pending_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == pclip_pkg::ST_MOVE || out_status == pclip_pkg::ST_REJECT)
    |-> out_start_x == '0 && out_start_y == '0 && out_end_x == '0 && out_end_y == '0)
    else $error("coordinates not zero for move or reject");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result without pending request");

endmodule

bind pen_line_clipper_top pclip_checker #(.COORD_BITS(COORD_BITS)) u_pclip_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_start_x (out_ch.start_x),
  .out_start_y (out_ch.start_y),
  .out_end_x   (out_ch.end_x),
  .out_end_y   (out_ch.end_y)
);

/* bench/pen_line_clipper_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the pen line clipper: directed table, then random requests.
module pen_line_clipper_top_tb;

  localparam int CB = 16;
  localparam longint CMAX = 32767;
  localparam longint CMIN = -32768;
  localparam int LIMIT = 1000000;

  typedef struct {
    pclip_pkg::req_type_t kind;
    logic [15:0]          x;
    logic [15:0]          y;
    logic                 has_exp;
    pclip_pkg::status_t   st;
    logic [15:0]          sx, sy, ex, ey;
  } stim_row_t;

  typedef struct packed {
    pclip_pkg::status_t st;
    logic [15:0]        sx, sy, ex, ey;
  } seg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = pclip_pkg::CFG_LEFT;
  logic [CB-1:0] cfg_wdata = '0;

  pclip_in_if #(.COORD_BITS(CB)) in_ch ();
  pclip_out_if #(.COORD_BITS(CB)) out_ch ();

  pen_line_clipper_top #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  longint win_l, win_r, win_t, win_b;
  longint pen_x, pen_y;
  seg_t seg_q[$];
  stim_row_t rows[$];
  int errors = 0;
  int cycles = 0;
  bit hold_long = 1'b0;

  // rounded, truncating line equation; products fit easily in 64 bits here
  function automatic longint solve_line(longint v, longint v0, longint w0,
                                        longint dv, longint dw);
    longint t, r, q;
    if (dv == 0) return w0;
    t = dw * (v - v0);
    r = (dv < 0 ? -dv : dv) / 2;
    q = (t < 0) ? (t - r) / dv : (t + r) / dv;
    return w0 + q;
  endfunction

  // -1 rejected, 0 untouched, 1 moved
  function automatic int clip_end(inout longint x, inout longint y, input longint x0,
                                  input longint y0, input longint dx, input longint dy);
    longint nx, ny;
    int c;
    nx = x; ny = y; c = 0;
    if (nx < win_l || nx > win_r) begin
      if (dx == 0) return -1;
      nx = nx < win_l ? win_l : win_r;
      ny = solve_line(nx, x0, y0, dx, dy);
      if (ny < win_t || ny > win_b) begin
        if (dy == 0) return -1;
        ny = ny < win_t ? win_t : win_b;
        nx = solve_line(ny, y0, x0, dy, dx);
        if (nx < win_l || nx > win_r) return -1;
      end
      c = 1;
    end
    if (ny < win_t || ny > win_b) begin
      if (dy == 0) return -1;
      ny = ny < win_t ? win_t : win_b;
      nx = solve_line(ny, y0, x0, dy, dx);
      if (nx < win_l || nx > win_r) begin
        if (dx == 0) return -1;
        nx = nx < win_l ? win_l : win_r;
        ny = solve_line(nx, x0, y0, dx, dy);
        if (ny < win_t || ny > win_b) return -1;
      end
      c = 1;
    end
    x = nx; y = ny;
    return c;
  endfunction

  function automatic longint clamp16(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic seg_t clip_request(pclip_pkg::req_type_t kind, logic [15:0] cx,
                                        logic [15:0] cy);
    seg_t s;
    longint x1, y1, x2, y2, dx, dy;
    int a, b;
    x1 = pen_x; y1 = pen_y;
    x2 = longint'($signed(cx));
    y2 = longint'($signed(cy));
    if (kind[0]) begin
      x2 = clamp16(pen_x + x2);
      y2 = clamp16(pen_y + y2);
    end
    pen_x = x2; pen_y = y2;
    s = '{pclip_pkg::ST_MOVE, 16'd0, 16'd0, 16'd0, 16'd0};
    if (!kind[1]) return s;
    s.st = pclip_pkg::ST_REJECT;
    if ((x1 < win_l && x2 < win_l) || (x1 > win_r && x2 > win_r) ||
        (y1 < win_t && y2 < win_t) || (y1 > win_b && y2 > win_b)) return s;
    dx = x2 - x1; dy = y2 - y1;
    begin
      longint x0, y0;
      x0 = x1; y0 = y1;
      a = clip_end(x1, y1, x0, y0, dx, dy);
      if (a < 0) return s;
      b = clip_end(x2, y2, x0, y0, dx, dy);
      if (b < 0) return s;
    end
    s.st = (a != 0 || b != 0) ? pclip_pkg::ST_CLIPPED : pclip_pkg::ST_UNCLIPPED;
    s.sx = x1[15:0]; s.sy = y1[15:0]; s.ex = x2[15:0]; s.ey = y2[15:0];
    return s;
  endfunction

  function automatic void add_row(pclip_pkg::req_type_t kind, logic [15:0] x,
                                  logic [15:0] y, logic has_exp = 1'b0,
                                  pclip_pkg::status_t st = pclip_pkg::ST_MOVE,
                                  logic [15:0] ex = 16'd0, logic [15:0] ey = 16'd0);
    stim_row_t r;
    r.kind = kind; r.x = x; r.y = y; r.has_exp = has_exp; r.st = st;
    r.sx = 16'd0; r.sy = 16'd0; r.ex = ex; r.ey = ey;
    rows.push_back(r);
  endfunction

  // cfg_we is left high between back-to-back writes and dropped by set_window
  task automatic write_window(pclip_pkg::cfg_index_t idx, longint v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[15:0];
    @(negedge clk);
    case (idx)
      pclip_pkg::CFG_LEFT:  win_l = v;
      pclip_pkg::CFG_RIGHT: win_r = v;
      pclip_pkg::CFG_TOP:   win_t = v;
      default:              win_b = v;
    endcase
  endtask

  task automatic set_window(longint l, longint r, longint t, longint b);
    write_window(pclip_pkg::CFG_LEFT, l);
    write_window(pclip_pkg::CFG_RIGHT, r);
    write_window(pclip_pkg::CFG_TOP, t);
    write_window(pclip_pkg::CFG_BOTTOM, b);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (seg_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  // valid stays high on return so back-to-back requests need no idle cycle
  task automatic send_request(pclip_pkg::req_type_t kind, logic [15:0] x, logic [15:0] y,
                              bit gaps, bit has_exp, seg_t want);
    seg_t p;
    int n;
    n = gaps ? int'($urandom_range(0, 13)) : 0;
    if (n != 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = clip_request(kind, x, y);
    if (has_exp && p != want)
      $display("%0t: table row disagrees with predictor status %0d/%0d", $time, want.st, p.st);
    seg_q.push_back(has_exp ? want : p);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord(bit near);
    int m;
    m = $urandom_range(0, 9);
    if (near) return 16'($signed($urandom_range(0, 1400)) - 200);
    if (m == 0) return 16'h8000;
    if (m == 1) return 16'h7fff;
    return 16'($urandom);
  endfunction

  // result checker
  always @(posedge clk) begin
    seg_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{pclip_pkg::status_t'(out_ch.status), out_ch.start_x, out_ch.start_y,
              out_ch.end_x, out_ch.end_y};
      if (seg_q.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, got.st);
        errors++;
      end else begin
        want = seg_q.pop_front();
        if (got.st != want.st) begin
          $display("%0t: status exp %0d got %0d", $time, want.st, got.st); errors++;
        end
        if (got.sx != want.sx) begin
          $display("%0t: start_x exp %0d got %0d", $time, $signed(want.sx), $signed(got.sx));
          errors++;
        end
        if (got.sy != want.sy) begin
          $display("%0t: start_y exp %0d got %0d", $time, $signed(want.sy), $signed(got.sy));
          errors++;
        end
        if (got.ex != want.ex) begin
          $display("%0t: end_x exp %0d got %0d", $time, $signed(want.ex), $signed(got.ex));
          errors++;
        end
        if (got.ey != want.ey) begin
          $display("%0t: end_y exp %0d got %0d", $time, $signed(want.ey), $signed(got.ey));
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int w;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_long = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13));
      if (w != 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    seg_t want;
    bit near;
    in_ch.valid = 1'b0;
    in_ch.req_type = pclip_pkg::REQ_MOVE_ABS;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    win_l = pclip_pkg::CLIP_LEFT_RST; win_r = pclip_pkg::CLIP_RIGHT_RST;
    win_t = pclip_pkg::CLIP_TOP_RST; win_b = pclip_pkg::CLIP_BOTTOM_RST;
    pen_x = 0; pen_y = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset window; expected values typed in where obvious
    add_row(pclip_pkg::REQ_DRAW_ABS, 16'd100, 16'd50, 1'b1, pclip_pkg::ST_UNCLIPPED,
            16'd100, 16'd50);
    add_row(pclip_pkg::REQ_MOVE_ABS, 16'h8000, 16'h8000, 1'b1, pclip_pkg::ST_MOVE);
    add_row(pclip_pkg::REQ_DRAW_ABS, 16'h8000, 16'h7fff, 1'b1, pclip_pkg::ST_REJECT);
    add_row(pclip_pkg::REQ_MOVE_REL, 16'h7fff, 16'h7fff, 1'b1, pclip_pkg::ST_MOVE);
    add_row(pclip_pkg::REQ_DRAW_REL, 16'h7fff, 16'h8000, 1'b1, pclip_pkg::ST_REJECT);
    add_row(pclip_pkg::REQ_MOVE_ABS, 16'd0, 16'd0, 1'b1, pclip_pkg::ST_MOVE);
    add_row(pclip_pkg::REQ_DRAW_REL, 16'd1023, 16'd767, 1'b1, pclip_pkg::ST_UNCLIPPED,
            16'd1023, 16'd767);
    add_row(pclip_pkg::REQ_DRAW_ABS, 16'd2000, 16'd767);
    add_row(pclip_pkg::REQ_MOVE_ABS, -16'sd50, 16'd300);
    add_row(pclip_pkg::REQ_DRAW_ABS, 16'd1500, 16'd900);
    add_row(pclip_pkg::REQ_DRAW_ABS, 16'd1500, -16'sd20);
    add_row(pclip_pkg::REQ_DRAW_ABS, -16'sd400, 16'd1200);
    add_row(pclip_pkg::REQ_DRAW_ABS, 16'd2000, -16'sd500);
    add_row(pclip_pkg::REQ_MOVE_ABS, 16'd500, -16'sd10);
    add_row(pclip_pkg::REQ_DRAW_REL, 16'd0, 16'd2000);
    add_row(pclip_pkg::REQ_MOVE_ABS, -16'sd5, 16'd10);
    add_row(pclip_pkg::REQ_DRAW_REL, 16'd0, 16'd10, 1'b1, pclip_pkg::ST_REJECT);
    add_row(pclip_pkg::REQ_DRAW_ABS, 16'h7fff, 16'h8000);
    add_row(pclip_pkg::REQ_DRAW_ABS, 16'h8000, 16'h7fff);
    foreach (rows[i]) begin
      want = '{rows[i].st, rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey};
      send_request(rows[i].kind, rows[i].x, rows[i].y, 1'b1, rows[i].has_exp, want);
    end
    drain_results();

    // inverted window, then full range, then the reset window, a single point and random ones
    set_window(500, 100, 400, 200);
    for (int i = 0; i < 12; i++)
      send_request(pclip_pkg::req_type_t'($urandom_range(0, 3)), rand_coord(1'b1),
                   rand_coord(1'b1), 1'b1, 1'b0, want);
    drain_results();
    set_window(CMIN, CMAX, CMIN, CMAX);
    for (int i = 0; i < 40; i++)
      send_request(pclip_pkg::req_type_t'($urandom_range(0, 3)), rand_coord(1'b0),
                   rand_coord(1'b0), 1'b1, 1'b0, want);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      longint a, b, c, d;
      a = $signed(16'($urandom)) / 4; b = a + $urandom_range(0, 3000);
      c = $signed(16'($urandom)) / 4; d = c + $urandom_range(0, 3000);
      if (ph == 0) begin a = 0; b = 1023; c = 0; d = 767; end
      if (ph == 1) begin a = 10; b = 10; c = -7; d = -7; end
      set_window(a, clamp16(b), c, clamp16(d));
      if (ph == 2) hold_long = 1'b1;
      for (int i = 0; i < 130; i++) begin
        near = $urandom_range(0, 3) != 0;
        send_request(pclip_pkg::req_type_t'($urandom_range(0, 3)),
                     near ? 16'(a + $signed($urandom_range(0, 2400)) - 600) : rand_coord(1'b0),
                     near ? 16'(c + $signed($urandom_range(0, 2400)) - 600) : rand_coord(1'b0),
                     ph != 3, 1'b0, want);
      end
      drain_results();
    end
    if (errors == 0 && seg_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* sim.f */
design/pclip_pkg.sv
design/pclip_if.sv
design/pclip_front.sv
design/pclip_fifo.sv
design/pclip_along.sv
design/pclip_back.sv
design/pen_line_clipper_top.sv
design/pclip_checker.sv
bench/pen_line_clipper_top_tb.sv
